// ----- src/i2r_pkg.sv -----
// shared types, constants and digit tables of the integer to roman encoder
package i2r_pkg;

   localparam int VALUE_W = 12;
   localparam int NUM_DIGITS = 4;
   localparam int SYMBOL_W = 7;

   localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

   typedef logic [3:0] digit_type;
   typedef logic [1:0] pos_type;
   typedef logic [2:0] count_type;
   typedef logic [SYMBOL_W-1:0] symbol_type;

   // status from the bcd converter
   typedef struct packed {
      logic done;
      digit_type [NUM_DIGITS-1:0] digits;
   } bcd_status_type;

   // decimal positions, units lowest and thousands highest
   localparam pos_type POS_UNITS = 2'd0;
   localparam pos_type POS_TENS = 2'd1;
   localparam pos_type POS_HUNDREDS = 2'd2;
   localparam pos_type POS_THOUSANDS = 2'd3;

   // symbol roles within one digit
   typedef enum logic [1:0] {
      ROLE_ONE,
      ROLE_FIVE,
      ROLE_TEN
   } role_type;

   // ascii letters
   localparam symbol_type SYM_I = 7'h49;
   localparam symbol_type SYM_V = 7'h56;
   localparam symbol_type SYM_X = 7'h58;
   localparam symbol_type SYM_L = 7'h4C;
   localparam symbol_type SYM_C = 7'h43;
   localparam symbol_type SYM_D = 7'h44;
   localparam symbol_type SYM_M = 7'h4D;
   localparam symbol_type SYM_NONE = 7'h00;

   // number of letters a decimal digit turns into
   function automatic count_type digit_length(input digit_type d);
      count_type len;
      case (d)
         4'd0, 4'd1, 4'd2, 4'd3: len = {1'b0, d[1:0]};
         4'd4: len = 3'd2;
         4'd5: len = 3'd1;
         4'd6, 4'd7, 4'd8: len = 3'(d - 4'd4);
         4'd9: len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // which role the k-th letter of a digit plays
   function automatic role_type digit_role(input digit_type d, input count_type k);
      role_type role;
      case (d)
         4'd9: role = (k == 3'd0) ? ROLE_ONE : ROLE_TEN;
         4'd5, 4'd6, 4'd7, 4'd8: role = (k == 3'd0) ? ROLE_FIVE : ROLE_ONE;
         4'd4: role = (k == 3'd0) ? ROLE_ONE : ROLE_FIVE;
         default: role = ROLE_ONE;
      endcase
      return role;
   endfunction

   // letter for a role at a decimal position
   function automatic symbol_type role_symbol(input pos_type pos, input role_type role);
      symbol_type sym;
      unique case (pos)
         POS_THOUSANDS: sym = SYM_M;
         POS_HUNDREDS: begin
            case (role)
               ROLE_ONE: sym = SYM_C;
               ROLE_FIVE: sym = SYM_D;
               default: sym = SYM_M;
            endcase
         end
         POS_TENS: begin
            case (role)
               ROLE_ONE: sym = SYM_X;
               ROLE_FIVE: sym = SYM_L;
               default: sym = SYM_C;
            endcase
         end
         default: begin
            case (role)
               ROLE_ONE: sym = SYM_I;
               ROLE_FIVE: sym = SYM_V;
               default: sym = SYM_X;
            endcase
         end
      endcase
      return sym;
   endfunction

endpackage

// ----- src/i2r_bcd.sv -----
// bit-serial binary to bcd converter, one input bit per cycle
module i2r_bcd (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [i2r_pkg::VALUE_W-1:0] value,
   output i2r_pkg::bcd_status_type status
);
   import i2r_pkg::*;

   localparam int BCD_W = NUM_DIGITS * 4;
   localparam logic [3:0] LAST_STEP = 4'(VALUE_W - 1);

   logic [VALUE_W-1:0] shift_ff;
   logic [BCD_W-1:0] bcd_ff;
   logic [BCD_W-1:0] adjusted;
   logic [3:0] step_ff;
   logic busy_ff;
   logic done_ff;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adjusted[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adjusted[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // shift sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            shift_ff <= value;
            bcd_ff <= '0;
         end else if (busy_ff) begin
            bcd_ff <= {adjusted[BCD_W-2:0], shift_ff[VALUE_W-1]};
            shift_ff <= {shift_ff[VALUE_W-2:0], 1'b0};
            step_ff <= step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.done = done_ff;
   assign status.digits = bcd_ff;

endmodule

// ----- src/integer_to_roman_encoder.sv -----
// integer to roman numeral encoder, one ascii letter per response
//
//  channel  dir  fields (low bit up)                        handshake
//  req      in   tdata: value[11:0], zero pad               tvalid/tready
//  rsp      out  tdata: symbol[6:0], zero pad; tlast: last;  tvalid/tready
//                tuser: bad_input
//
// a request is taken only while the sequencer is idle; its value then goes through
// bit-serial bcd conversion, and the letters are loaded one per response, with each
// zero leading or inner digit skipped. the conversion shift loop and the one-letter
// output register set the request rate. an out-of-range value passes through the
// error state to its single error response. reset is synchronous and clears the
// sequencer and output valid. a stalled response holds the letter sequencer; the
// next request is taken while the last letter still waits.
module integer_to_roman_encoder (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,   // value[11:0], zero [15:12]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,    // symbol[6:0], zero [7]
   output logic rsp_tlast,
   output logic rsp_tuser           // bad_input
);
   import i2r_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT,
      ST_ERROR
   } state_type;

   state_type state_ff;
   pos_type pos_ff;
   count_type cnt_ff;
   logic rsp_valid_ff;
   symbol_type symbol_ff;
   logic last_ff;
   logic bad_ff;

   logic [VALUE_W-1:0] value;
   logic req_accept;
   logic value_bad;
   logic bcd_start;
   bcd_status_type bcd_status;
   digit_type cur_digit;
   count_type cur_len;
   symbol_type cur_symbol;
   logic rest_zero;
   logic slot_free;
   logic digit_end;
   logic rsp_load;
   logic rsp_valid_in;

   // request decode and range check
   assign value = req_tdata[VALUE_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign value_bad = (value == '0) || (value > VALUE_MAX);
   assign bcd_start = req_accept && !value_bad;

   i2r_bcd u_bcd (
      .clock(clock),
      .reset(reset),
      .start(bcd_start),
      .value(value),
      .status(bcd_status)
   );

   // current digit and its letter
   assign cur_digit = bcd_status.digits[pos_ff];
   assign cur_len = digit_length(cur_digit);
   assign cur_symbol = role_symbol(pos_ff, digit_role(cur_digit, cnt_ff));
   assign digit_end = (3'(cnt_ff + 3'd1) == cur_len);

   // all lower digits empty means this digit ends the numeral
   always_comb begin
      rest_zero = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if ((2'(i) < pos_ff) && (bcd_status.digits[i] != '0)) begin
            rest_zero = 1'b0;
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // response valid loads on a letter or an error, drops when taken
   assign rsp_load = slot_free && ((state_ff == ST_ERROR)
                     || ((state_ff == ST_EMIT) && (cur_len != '0)));
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff <= POS_THOUSANDS;
         cnt_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= value_bad ? ST_ERROR : ST_CONV;
               end
            end
            ST_CONV: begin
               if (bcd_status.done) begin
                  state_ff <= ST_EMIT;
                  pos_ff <= POS_THOUSANDS;
                  cnt_ff <= '0;
               end
            end
            ST_ERROR: begin
               if (slot_free) begin
                  symbol_ff <= SYM_NONE;
                  last_ff <= 1'b1;
                  bad_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (cur_len == '0) begin
                  pos_ff <= pos_ff - 2'd1;
               end else if (slot_free) begin
                  symbol_ff <= cur_symbol;
                  last_ff <= digit_end && rest_zero;
                  bad_ff <= 1'b0;
                  if (digit_end) begin
                     cnt_ff <= '0;
                     if (rest_zero) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        pos_ff <= pos_ff - 2'd1;
                     end
                  end else begin
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, symbol_ff};
   assign rsp_tlast = last_ff;
   assign rsp_tuser = bad_ff;

endmodule
